[rtl/mie_pkg.sv]
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WIDTH-1:0] gcd_out;
    logic             has_inverse;
    logic [WIDTH-1:0] inverse;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic update;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic r1_zero;
    logic div_last;
    logic mul_last;
  } dp_sts_t;

endpackage

[rtl/mie_datapath.sv]
module mie_datapath (
  input  logic                clk,
  input  mie_pkg::in_item_t   in_item,
  input  mie_pkg::dp_cmd_t    cmd,
  output mie_pkg::dp_sts_t    sts,
  output mie_pkg::out_item_t  result
);
  import mie_pkg::*;

  logic [WIDTH-1:0] m_r, m_nxt;
  logic             track_r, track_nxt;
  logic [WIDTH-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  // Restoring divider state: quotient shifts in, remainder builds up.
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // Shift-and-add modular multiplier state.
  logic [WIDTH-1:0] ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_diff;
  logic [WIDTH-1:0] acc_add, ma_dbl, t_new;

  // Modular add of a and b, both below m.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  always_comb begin
    rem_sh   = {rem_r, q_r[WIDTH-1]};
    rem_diff = rem_sh - {1'b0, r1_r};
    acc_add  = add_mod(acc_r, ma_r, m_r);
    ma_dbl   = add_mod(ma_r, ma_r, m_r);
    t_new    = (t0_r >= acc_r) ? (t0_r - acc_r) : (t0_r + (m_r - acc_r));
  end

  always_comb begin
    m_nxt = m_r; track_nxt = track_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    ma_nxt = ma_r; mb_nxt = mb_r; acc_nxt = acc_r;
    if (cmd.load) begin
      m_nxt     = in_item.modulus;
      track_nxt = (in_item.modulus != '0);
      r0_nxt    = in_item.modulus;
      r1_nxt    = in_item.value;
      t0_nxt    = '0;
      t1_nxt    = (in_item.modulus > WIDTH'(1)) ? WIDTH'(1) : '0;
    end
    if (cmd.div_start) begin
      q_nxt   = r0_r;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(WIDTH);
    end
    // One quotient bit per cycle.
    if (cmd.div_step) begin
      if (!rem_diff[WIDTH]) begin
        rem_nxt = rem_diff[WIDTH-1:0];
        q_nxt   = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WIDTH-1:0];
        q_nxt   = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    // Multiplier takes t1 as the doubled operand and q as the scanned bits;
    // t1 < m, so doubling keeps it reduced and q need not be folded first.
    if (cmd.mul_start) begin
      ma_nxt  = t1_r;
      mb_nxt  = q_r;
      acc_nxt = '0;
    end
    if (cmd.mul_step) begin
      if (mb_r[0]) acc_nxt = acc_add;
      ma_nxt = ma_dbl;
      mb_nxt = mb_r >> 1;
    end
    if (cmd.update) begin
      if (track_r) begin
        t0_nxt = t1_r;
        t1_nxt = t_new;
      end
      r0_nxt = r1_r;
      r1_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt; track_r <= track_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; acc_r <= acc_nxt;
  end

  assign sts.r1_zero  = (r1_r == '0);
  assign sts.div_last = (cnt_r == CNT_W'(1));
  assign sts.mul_last = (mb_r == '0);

  assign result.gcd_out     = r0_r;
  assign result.has_inverse = track_r && (r0_r == WIDTH'(1));
  assign result.inverse     = (track_r && (r0_r == WIDTH'(1))) ? t0_r : '0;

endmodule

[rtl/mie_ctrl.sv]
module mie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              capture,
  output mie_pkg::dp_cmd_t  cmd,
  input  mie_pkg::dp_sts_t  sts
);
  import mie_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    capture   = 1'b0;
    in_ready  = (state_r == ST_IDLE);
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.r1_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // This state loads the multiplier from the finished quotient.
        cmd.mul_start = 1'b1;
        state_nxt     = ST_UPD;
      end
      ST_UPD: begin
        if (sts.mul_last) begin
          cmd.update = 1'b1;
          state_nxt  = ST_CHECK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ovalid_nxt) begin
          capture    = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ovalid_r;

endmodule

[rtl/modular_inverse_ext_euclid.sv]
// Each Euclid step runs a bit-serial restoring division, then a bit-serial modular
// multiply and the update of the remainders and coefficients.
// Requests are handled one at a time: a new one is accepted only while idle.
// Reset: rst_n is synchronous, active low; clears the controller and out_valid.
module modular_inverse_ext_euclid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mie_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mie_pkg::out_item_t  out_data
);
  import mie_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t result;
  out_item_t out_r;
  logic      capture;

  mie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .capture(capture),
    .cmd(cmd), .sts(sts)
  );

  mie_datapath u_dp (
    .clk(clk), .in_item(in_data), .cmd(cmd), .sts(sts), .result(result)
  );

  // Output register holds the finished request until taken.
  always_ff @(posedge clk) begin
    if (capture) out_r <= result;
  end

  assign out_data = out_r;

endmodule
